>>> rtl/core/assert_macros.svh
// Assertion macros shared by the timer table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define OTMT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define OTMT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define OTMT_ASSERT(lbl, prop, msg)
`define OTMT_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/core/otmt_pkg.sv
// Types and constants of the one-shot timer table.
package otmt_pkg;

	// Input opcodes.
	localparam logic [2:0] OP_INSERT   = 3'd0;
	localparam logic [2:0] OP_CANCEL   = 3'd1;
	localparam logic [2:0] OP_CLEAR    = 3'd2;
	localparam logic [2:0] OP_TICK     = 3'd3;
	localparam logic [2:0] OP_SET_TIME = 3'd4;

	// Result codes.
	localparam logic       KIND_STATUS = 1'b0;
	localparam logic       KIND_EXPIRY = 1'b1;
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_REJECTED  = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// Command class decided by the front end.
	typedef enum logic [2:0] {
		CLS_INSERT,
		CLS_INSERT_BAD,
		CLS_CANCEL,
		CLS_CLEAR,
		CLS_TICK,
		CLS_SET_TIME,
		CLS_ILLEGAL
	} cls_t;

	typedef struct packed {
		cls_t        cls;
		logic [7:0]  id;
		logic [31:0] handler;
		logic [31:0] data;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [7:0]  id;
		logic [31:0] handler;
		logic [31:0] data;
		logic [31:0] tick;
		logic        last;
	} res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DEC,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

>>> rtl/core/otmt_fifo.sv
// Small first-in first-out queue of fixed-width requests.
module otmt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = buf_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/core/otmt_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module otmt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [2:0]      opcode,
	input  logic [7:0]      timer_id,
	input  logic [31:0]     handler,
	input  logic [31:0]     user_data,
	input  logic [31:0]     delay_ticks,
	input  logic [31:0]     load_ticks,
	output logic            cmd_empty,
	input  logic            cmd_pop,
	output otmt_pkg::cmd_t  cmd
);
	otmt_pkg::cmd_t                   cls_cmd;
	logic [$bits(otmt_pkg::cmd_t)-1:0] rd_bits;

	// Decode the opcode and check insert parameters up front.
	always_comb begin
		cls_cmd.id      = timer_id;
		cls_cmd.handler = handler;
		cls_cmd.data    = user_data;
		cls_cmd.value   = (opcode == otmt_pkg::OP_SET_TIME) ? load_ticks : delay_ticks;
		case (opcode)
			otmt_pkg::OP_INSERT: begin
				cls_cmd.cls = (handler == '0 || delay_ticks == '0) ?
					otmt_pkg::CLS_INSERT_BAD : otmt_pkg::CLS_INSERT;
			end
			otmt_pkg::OP_CANCEL:   cls_cmd.cls = otmt_pkg::CLS_CANCEL;
			otmt_pkg::OP_CLEAR:    cls_cmd.cls = otmt_pkg::CLS_CLEAR;
			otmt_pkg::OP_TICK:     cls_cmd.cls = otmt_pkg::CLS_TICK;
			otmt_pkg::OP_SET_TIME: cls_cmd.cls = otmt_pkg::CLS_SET_TIME;
			default:               cls_cmd.cls = otmt_pkg::CLS_ILLEGAL;
		endcase
	end

	// Command queue between front and back.
	otmt_fifo #(
		.WIDTH($bits(otmt_pkg::cmd_t)),
		.DEPTH(2)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls_cmd),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (rd_bits),
		.empty (cmd_empty)
	);

	assign cmd = otmt_pkg::cmd_t'(rd_bits);

endmodule

>>> rtl/core/otmt_back.sv
// Back end: holds the timer slots and carries out queued commands.
module otmt_back #(
	parameter int SLOTS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_empty,
	output logic            cmd_pop,
	input  otmt_pkg::cmd_t  cmd,
	input  logic            res_full,
	output logic            res_push,
	output otmt_pkg::res_t  res
);
	localparam int ORDW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Slot storage; payload is only read for live slots.
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] due_q;
	logic [7:0]       id_q      [SLOTS];
	logic [31:0]      handler_q [SLOTS];
	logic [31:0]      data_q    [SLOTS];
	logic [31:0]      rem_q     [SLOTS];
	logic [ORDW-1:0]  order_q   [SLOTS];

	logic [31:0]      tick_q;
	otmt_pkg::state_t state_q, state_d;
	logic             is_tick_q;
	logic [7:0]       cid_q;
	logic             hit_q;
	logic [ORDW-1:0]  scan_q;
	logic [ORDW-1:0]  rm_cnt_q;

	logic             free_any;
	logic [IDXW-1:0]  free_idx;
	logic [SLOTS-1:0] match;
	logic [SLOTS-1:0] remove;
	logic             any_rm;
	logic             last_rank;
	logic             advance;
	logic             do_insert;
	logic [7:0]       sel_id;
	logic [31:0]      sel_handler;
	logic [31:0]      sel_data;

	// Lowest free slot for an insert.
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IDXW'(i);
			end
		end
	end

	// Slot holding the rank under scan, and whether it leaves the table.
	always_comb begin
		sel_id      = '0;
		sel_handler = '0;
		sel_data    = '0;
		for (int i = 0; i < SLOTS; i++) begin
			match[i]  = valid_q[i] && (order_q[i] == scan_q);
			remove[i] = match[i] && (is_tick_q ? due_q[i] : (id_q[i] == cid_q));
			if (match[i]) begin
				sel_id      = sel_id | id_q[i];
				sel_handler = sel_handler | handler_q[i];
				sel_data    = sel_data | data_q[i];
			end
		end
		any_rm = |remove;
	end

	assign last_rank = (scan_q == ORDW'(SLOTS - 1));
	assign advance   = (state_q == otmt_pkg::S_SCAN) && !res_full;
	assign do_insert = cmd_pop && (cmd.cls == otmt_pkg::CLS_INSERT) && free_any;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			otmt_pkg::S_IDLE: begin
				if (!cmd_empty && !res_full) begin
					if (cmd.cls == otmt_pkg::CLS_CANCEL) begin
						state_d = otmt_pkg::S_SCAN;
					end else if (cmd.cls == otmt_pkg::CLS_TICK) begin
						state_d = otmt_pkg::S_DEC;
					end
				end
			end
			otmt_pkg::S_DEC:  state_d = otmt_pkg::S_SCAN;
			otmt_pkg::S_SCAN: begin
				if (!res_full && last_rank) begin
					state_d = otmt_pkg::S_DONE;
				end
			end
			otmt_pkg::S_DONE: begin
				if (!res_full) begin
					state_d = otmt_pkg::S_IDLE;
				end
			end
			default: state_d = otmt_pkg::S_IDLE;
		endcase
	end

	// Outputs: command pop and result request.
	always_comb begin
		cmd_pop      = 1'b0;
		res_push     = 1'b0;
		res.kind     = otmt_pkg::KIND_STATUS;
		res.status   = otmt_pkg::ST_OK;
		res.id       = '0;
		res.handler  = '0;
		res.data     = '0;
		res.tick     = tick_q;
		res.last     = 1'b1;
		case (state_q)
			otmt_pkg::S_IDLE: begin
				cmd_pop  = !cmd_empty && !res_full;
				res_push = cmd_pop && (cmd.cls != otmt_pkg::CLS_CANCEL) &&
					(cmd.cls != otmt_pkg::CLS_TICK);
				case (cmd.cls)
					otmt_pkg::CLS_INSERT: begin
						res.status = free_any ? otmt_pkg::ST_OK : otmt_pkg::ST_REJECTED;
					end
					otmt_pkg::CLS_INSERT_BAD: res.status = otmt_pkg::ST_REJECTED;
					otmt_pkg::CLS_ILLEGAL:    res.status = otmt_pkg::ST_REJECTED;
					otmt_pkg::CLS_SET_TIME:   res.tick   = cmd.value;
					default:                  res.status = otmt_pkg::ST_OK;
				endcase
			end
			otmt_pkg::S_SCAN: begin
				res_push    = !res_full && is_tick_q && any_rm;
				res.kind    = otmt_pkg::KIND_EXPIRY;
				res.id      = sel_id;
				res.handler = sel_handler;
				res.data    = sel_data;
				res.last    = 1'b0;
			end
			otmt_pkg::S_DONE: begin
				res_push   = !res_full;
				res.status = (is_tick_q || hit_q) ? otmt_pkg::ST_OK : otmt_pkg::ST_NOT_FOUND;
			end
			default: res_push = 1'b0;
		endcase
	end

	// Slot payload and countdown.
	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			if (state_q == otmt_pkg::S_DEC && valid_q[i]) begin
				rem_q[i] <= rem_q[i] - 32'd1;
			end
			if (do_insert && free_idx == IDXW'(i)) begin
				id_q[i]      <= cmd.id;
				handler_q[i] <= cmd.handler;
				data_q[i]    <= cmd.data;
				rem_q[i]     <= cmd.value;
				order_q[i]   <= '0;
			end else if (do_insert && valid_q[i]) begin
				order_q[i] <= order_q[i] + ORDW'(1);
			end else if (advance && match[i] && !remove[i]) begin
				// Close the gaps left by slots removed at lower ranks.
				order_q[i] <= scan_q - rm_cnt_q;
			end
		end
	end

	// Slot validity and expiry marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			due_q   <= '0;
		end else begin
			for (int i = 0; i < SLOTS; i++) begin
				if (state_q == otmt_pkg::S_DEC) begin
					due_q[i] <= valid_q[i] && (rem_q[i] == 32'd1);
				end
				if (do_insert && free_idx == IDXW'(i)) begin
					valid_q[i] <= 1'b1;
				end else if (advance && remove[i]) begin
					valid_q[i] <= 1'b0;
				end
			end
			if (cmd_pop && cmd.cls == otmt_pkg::CLS_CLEAR) begin
				valid_q <= '0;
			end
		end
	end

	// Sequencer, tick counter and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= otmt_pkg::S_IDLE;
			tick_q    <= '0;
			is_tick_q <= 1'b0;
			cid_q     <= '0;
			hit_q     <= 1'b0;
			scan_q    <= '0;
			rm_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd_pop) begin
				is_tick_q <= (cmd.cls == otmt_pkg::CLS_TICK);
				cid_q     <= cmd.id;
				hit_q     <= 1'b0;
				scan_q    <= '0;
				rm_cnt_q  <= '0;
				if (cmd.cls == otmt_pkg::CLS_SET_TIME) begin
					tick_q <= cmd.value;
				end
			end
			if (state_q == otmt_pkg::S_DEC) begin
				tick_q <= tick_q + 32'd1;
			end
			if (advance) begin
				scan_q <= scan_q + ORDW'(1);
				if (any_rm) begin
					hit_q    <= 1'b1;
					rm_cnt_q <= rm_cnt_q + ORDW'(1);
				end
			end
		end
	end

endmodule

>>> rtl/core/one_shot_timer_table.sv
// Top level of the one-shot timer table.
// Requests enter through a queue-style port: an item is taken at a clock edge
// where push is high and full is low. Results leave through a second queue:
// the oldest result sits on the result ports while empty is low and is taken
// at an edge where pop is high. Every request yields one status result with
// last set; a tick first yields one expiry result per timer that ran out,
// newest inserted first.
// Insert, clear, set-time and illegal requests are carried out in the back end's
// idle state; their status result is pushed into the result queue as it pops them.
// Cancel pops in the idle state, walks all SLOTS insertion ranks, one per cycle
// while the result queue is not full, and then reports its status; a tick adds
// a countdown step before the walk. A two-entry request queue decouples intake
// from execution, so requests are taken while the back end is busy until that
// queue fills.
// Reset empties the table, both queues and clears the tick counter.
// When the receiver stalls, the result queue fills and the back end holds its
// current step until there is room again; no result is dropped.
module one_shot_timer_table #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  opcode,
	input  logic [7:0]  timer_id,
	input  logic [31:0] handler,
	input  logic [31:0] user_data,
	input  logic [31:0] delay_ticks,
	input  logic [31:0] load_ticks,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [1:0]  status,
	output logic [7:0]  expired_id,
	output logic [31:0] expired_handler,
	output logic [31:0] expired_data,
	output logic [31:0] tick_count,
	output logic        last
);
	`include "assert_macros.svh"

	otmt_pkg::cmd_t                    cmd;
	logic                              cmd_empty, cmd_pop;
	otmt_pkg::res_t                    res, res_out;
	logic                              res_push, res_full;
	logic [$bits(otmt_pkg::res_t)-1:0] res_bits;

	// Intake and classification.
	otmt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.opcode     (opcode),
		.timer_id   (timer_id),
		.handler    (handler),
		.user_data  (user_data),
		.delay_ticks(delay_ticks),
		.load_ticks (load_ticks),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd)
	);

	// Execution against the slot table.
	otmt_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	// Result queue toward the receiver.
	otmt_fifo #(
		.WIDTH($bits(otmt_pkg::res_t)),
		.DEPTH(4)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_bits),
		.empty (empty)
	);

	assign res_out         = otmt_pkg::res_t'(res_bits);
	assign kind            = res_out.kind;
	assign status          = res_out.status;
	assign expired_id      = res_out.id;
	assign expired_handler = res_out.handler;
	assign expired_data    = res_out.data;
	assign tick_count      = res_out.tick;
	assign last            = res_out.last;

	`OTMT_NEVER(a_no_push_full, res_push && res_full, "result pushed into a full queue")
	`OTMT_ASSERT(a_push_shows, res_push |=> !empty, "pushed result not visible")
	`OTMT_NEVER(a_expiry_not_last, !empty && kind == otmt_pkg::KIND_EXPIRY && last, "bad last")
	`OTMT_NEVER(a_status_last, !empty && kind == otmt_pkg::KIND_STATUS && !last, "no last")

endmodule
